// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg: shared types and constants for the indexed LIFO stack
// Operation and status codes, widths, and the control bundle that the
// sequencer drives into the row of storage cells.
// ----------------------------------------------------------------------------
package ils_pkg;

  // Number of storage cells in the row (entries the stack can ever hold).
  localparam int MAX_DEPTH = 256;

  // Fixed field widths of the ports.
  localparam int VAL_W   = 32;
  localparam int POS_W   = 9;
  localparam int DEPTH_W = 9;
  localparam int CAP_W   = 9;

  // Widths derived from the row length.
  localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_DEPTH + 1);
  // Common width for comparing fill count against port-width values.
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_PEEK   = 2'd2,
    OP_CHANGE = 2'd3
  } ils_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_RANGE     = 2'd3
  } ils_status_e;

  typedef enum logic {
    S_IDLE,
    S_SEEK
  } ils_state_e;

  // Control broadcast to every cell.
  typedef struct packed {
    logic             we;     // write the cell selected by idx
    logic [IDX_W-1:0] idx;    // write index, counted from the bottom
    logic [VAL_W-1:0] wdata;  // word to write
    logic             load;   // copy each entry into its chain stage
    logic             shift;  // move the chain one cell toward cell 0
  } ils_cell_ctl_t;

endpackage

// File: rtl/indexed_lifo_stack_unit.sv
// ----------------------------------------------------------------------------
// indexed_lifo_stack_unit: bounded LIFO stack of signed words with peek
// Push, pop, peek-from-top and change-at-index over a row of storage cells,
// one result beat per operation with status and depth.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and gives exactly
// one result beat: valid_o is high for one cycle with data_o, status_o and
// depth_o, and the receiver cannot stall it. Push, change and every operation
// that ends in an error strobe their result in the cycle after acceptance and
// leave busy low, so one such operation can be started every cycle. Pop and a
// successful peek read the entry at index k from the bottom (k = depth - 1 for
// pop, depth - position for peek): every cell copies its word into a read
// chain, the chain moves one cell toward the bottom per cycle, so the word
// reaches cell 0 after k shifts and is then registered into the result
// beat, with busy high in between; the wait is set by the chain walk.
// Capacity is to be written through cfg_we_i / cfg_data_i only while idle;
// the block itself does not enforce this. Zero acts as one and values
// above the row length saturate. Entries start undefined; only written
// entries are ever read.
// ----------------------------------------------------------------------------
module indexed_lifo_stack_unit
  import ils_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // capacity register
  input  logic                      cfg_we_i,
  input  logic [CAP_W-1:0]          cfg_data_i,
  // command side
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                op_i,
  input  logic signed [VAL_W-1:0]   value_i,
  input  logic [POS_W-1:0]          position_i,
  // result side
  output logic                      valid_o,
  output logic signed [VAL_W-1:0]   data_o,
  output logic [1:0]                status_o,
  output logic [DEPTH_W-1:0]        depth_o
);

  ils_cell_ctl_t    cell_ctl;
  logic [VAL_W-1:0] chain [MAX_DEPTH];
  logic [VAL_W-1:0] data_raw;

  // Sequencer: fill count, capacity, op decode, result register.
  ils_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .value_i      (value_i),
    .position_i   (position_i),
    .chain_head_i (chain[0]),
    .ctl_o        (cell_ctl),
    .valid_o      (valid_o),
    .data_o       (data_raw),
    .status_o     (status_o),
    .depth_o      (depth_o)
  );

  assign data_o = data_raw;

  // Row of cells; cell i holds entry i counted from the bottom. The read
  // chain runs from the top cell down to cell 0, which feeds the sequencer.
  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    logic             wr_sel;
    logic [VAL_W-1:0] next_word;

    assign wr_sel = cell_ctl.we && (cell_ctl.idx == IDX_W'(i));

    if (i == MAX_DEPTH - 1) begin : g_top
      assign next_word = '0;
    end else begin : g_mid
      assign next_word = chain[i+1];
    end

    ils_cell u_cell (
      .clk_i    (clk_i),
      .wr_sel_i (wr_sel),
      .ctl_i    (cell_ctl),
      .next_i   (next_word),
      .chain_o  (chain[i])
    );
  end

endmodule

// File: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell: one stack entry plus its stage of the read chain
// Holds one word; on load copies it into the chain stage, on shift takes
// the chain stage of its upper neighbor.
// ----------------------------------------------------------------------------
module ils_cell
  import ils_pkg::*;
(
  input  logic             clk_i,
  input  logic             wr_sel_i,
  input  ils_cell_ctl_t    ctl_i,
  input  logic [VAL_W-1:0] next_i,
  output logic [VAL_W-1:0] chain_o
);

  logic [VAL_W-1:0] entry_q;
  logic [VAL_W-1:0] chain_q;

  always_ff @(posedge clk_i) begin
    if (wr_sel_i) begin
      entry_q <= ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      chain_q <= entry_q;
    end else if (ctl_i.shift) begin
      chain_q <= next_i;
    end
  end

  assign chain_o = chain_q;

endmodule

// File: rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl: operation sequencer for the indexed LIFO stack
// Keeps fill count and capacity, decodes each operation, steers the cell
// row and registers the result beat.
// ----------------------------------------------------------------------------
module ils_ctrl
  import ils_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CAP_W-1:0]   cfg_data_i,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic [VAL_W-1:0]   value_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [VAL_W-1:0]   chain_head_i,
  output ils_cell_ctl_t      ctl_o,
  output logic               valid_o,
  output logic [VAL_W-1:0]   data_o,
  output logic [1:0]         status_o,
  output logic [DEPTH_W-1:0] depth_o
);

  localparam logic [CMP_W-1:0] MaxX = CMP_W'(MAX_DEPTH);

  ils_state_e         state_q, state_d;
  logic [CAP_W-1:0]   cap_q;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               valid_q, valid_d;
  logic [VAL_W-1:0]   data_q, data_d;
  ils_status_e        status_q, status_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;

  logic               accept;
  logic [CMP_W-1:0]   fill_x, cap_x, eff_cap, pos_x;
  logic               full;
  ils_status_e        op_status;
  logic               op_seek;
  logic               op_we;
  logic [CMP_W-1:0]   op_idx;
  logic [CMP_W-1:0]   op_addr;
  logic [CMP_W-1:0]   fill_next_x;

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);

  // Effective capacity: zero reads as one, saturates at the row length.
  always_comb begin
    fill_x = CMP_W'(fill_q);
    cap_x  = CMP_W'(cap_q);
    pos_x  = CMP_W'(position_i);
    if (cap_x == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_x > MaxX) begin
      eff_cap = MaxX;
    end else begin
      eff_cap = cap_x;
    end
    full = (fill_x >= eff_cap);
  end

  // Operation decode.
  always_comb begin
    op_status   = ST_OK;
    op_seek     = 1'b0;
    op_we       = 1'b0;
    op_idx      = fill_x;
    op_addr     = '0;
    fill_next_x = fill_x;
    unique case (ils_op_e'(op_i))
      OP_PUSH: begin
        if (full) begin
          op_status = ST_OVERFLOW;
        end else begin
          op_we       = 1'b1;
          op_idx      = fill_x;
          fill_next_x = fill_x + CMP_W'(1);
        end
      end
      OP_POP: begin
        if (fill_x == '0) begin
          op_status = ST_UNDERFLOW;
        end else begin
          op_seek     = 1'b1;
          op_addr     = fill_x - CMP_W'(1);
          fill_next_x = fill_x - CMP_W'(1);
        end
      end
      OP_PEEK: begin
        if ((pos_x == '0) || (pos_x > fill_x)) begin
          op_status = ST_RANGE;
        end else begin
          op_seek = 1'b1;
          op_addr = fill_x - pos_x;
        end
      end
      OP_CHANGE: begin
        if (pos_x >= fill_x) begin
          op_status = ST_RANGE;
        end else begin
          op_we  = 1'b1;
          op_idx = pos_x;
        end
      end
      default: begin
        op_status = ST_OK;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && op_seek) begin
          state_d = S_SEEK;
        end
      end
      S_SEEK: begin
        if (cnt_q == '0) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs, cell control and datapath registers.
  always_comb begin
    ctl_o.we    = 1'b0;
    ctl_o.idx   = op_idx[IDX_W-1:0];
    ctl_o.wdata = value_i;
    ctl_o.load  = 1'b0;
    ctl_o.shift = 1'b0;
    fill_d      = fill_q;
    cnt_d       = cnt_q;
    valid_d     = 1'b0;
    data_d      = data_q;
    status_d    = status_q;
    depth_d     = depth_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ctl_o.we   = op_we;
          ctl_o.load = op_seek;
          fill_d     = fill_next_x[CNT_W-1:0];
          cnt_d      = op_addr[IDX_W-1:0];
          status_d   = op_status;
          depth_d    = DEPTH_W'(fill_next_x);
          data_d     = '0;
          valid_d    = !op_seek;
        end
      end
      S_SEEK: begin
        if (cnt_q == '0) begin
          valid_d = 1'b1;
          data_d  = chain_head_i;
        end else begin
          ctl_o.shift = 1'b1;
          cnt_d       = cnt_q - IDX_W'(1);
        end
      end
      default: begin
        valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_W'(256);
      fill_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    data_q   <= data_d;
    status_q <= status_d;
    depth_q  <= depth_d;
  end

  assign valid_o  = valid_q;
  assign data_o   = data_q;
  assign status_o = status_q;
  assign depth_o  = depth_q;

endmodule

// File: rtl/ils_checker.sv
// ----------------------------------------------------------------------------
// ils_checker: port-level checks for the indexed LIFO stack
// Watches commands and result beats on the top-level ports.
// ----------------------------------------------------------------------------
module ils_checker
  import ils_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         op_i,
  input logic               valid_o,
  input logic [VAL_W-1:0]   data_o,
  input logic [1:0]         status_o,
  input logic [DEPTH_W-1:0] depth_o
);

  // Error beats never carry a word.
  a_err_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != ST_OK)) |-> (data_o == '0))
    else $error("error beat with nonzero data");

  // Writes answer in the next cycle.
  a_write_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((op_i == OP_PUSH) || (op_i == OP_CHANGE))) |=> valid_o)
    else $error("push/change without result beat");

  // A successful push leaves a non-empty stack.
  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (op_i == OP_PUSH)) |=>
      ((status_o == ST_OVERFLOW) || (depth_o != '0)))
    else $error("push reported empty stack");

  // No beat while a read walks the chain.
  a_no_beat_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result beat while busy");

  // Busy only rises on an accepted command.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without command");

endmodule

bind indexed_lifo_stack_unit ils_checker u_ils_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .op_i     (op_i),
  .valid_o  (valid_o),
  .data_o   (data_o),
  .status_o (status_o),
  .depth_o  (depth_o)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_lifo_stack_unit
// Drives push, pop, peek and change commands through the start/busy handshake.
// A shadow stack in the bench predicts every result beat. Each beat is checked
// field by field against the oldest pending prediction. Directed cases cover
// the empty stack, word extremes, a capacity lowered below the depth and a full
// row. Random phases then sweep several capacity settings.
// ----------------------------------------------------------------------------
module tb;
  import ils_pkg::*;

  localparam int     CLK_PERIOD     = 10;
  localparam int     MAX_GAP        = 17;
  localparam int     OPS_PER_PHASE  = 200;
  // worst beat is a pop from a full row plus a full gap
  localparam longint CYCLE_LIMIT    = 3_000_000;

  localparam logic signed [VAL_W-1:0] WORD_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] WORD_MAX = ~WORD_MIN;

  typedef struct {
    logic signed [VAL_W-1:0] data;
    ils_status_e             status;
    logic [DEPTH_W-1:0]      depth;
  } stack_result_t;

  // DUT ports; every input starts at a known value
  logic                    clk_i      = 1'b0;
  logic                    rst_ni     = 1'b0;
  logic                    cfg_we_i   = 1'b0;
  logic [CAP_W-1:0]        cfg_data_i = '0;
  logic                    start      = 1'b0;
  logic                    busy;
  logic [1:0]              op_i       = OP_PUSH;
  logic signed [VAL_W-1:0] value_i    = '0;
  logic [POS_W-1:0]        position_i = '0;
  logic                    valid_o;
  logic signed [VAL_W-1:0] data_o;
  logic [1:0]              status_o;
  logic [DEPTH_W-1:0]      depth_o;

  // Shadow of the stack contents, fill level and capacity register.
  logic signed [VAL_W-1:0] shadow_words [MAX_DEPTH];
  int unsigned             shadow_fill     = 0;
  logic [CAP_W-1:0]        shadow_capacity = CAP_W'(256);

  // Predicted beats, oldest first.
  stack_result_t           results_due [$];
  int unsigned             error_count = 0;
  // When set, commands go out back to back with no gaps.
  bit                      burst_mode  = 1'b0;

  indexed_lifo_stack_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .value_i    (value_i),
    .position_i (position_i),
    .valid_o    (valid_o),
    .data_o     (data_o),
    .status_o   (status_o),
    .depth_o    (depth_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hang anywhere ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Applies one command to the shadow stack and returns the beat it must give.
  function automatic stack_result_t apply_stack_op(ils_op_e op,
                                                   logic signed [VAL_W-1:0] word,
                                                   logic [POS_W-1:0] pos);
    stack_result_t res;
    int unsigned   limit;
    res.data   = '0;
    res.status = ST_OK;
    // zero acts as one, anything past the row saturates
    limit = shadow_capacity;
    if (limit == 0) limit = 1;
    if (limit > MAX_DEPTH) limit = MAX_DEPTH;
    case (op)
      OP_PUSH: begin
        if (shadow_fill >= limit) begin
          res.status = ST_OVERFLOW;
        end else begin
          shadow_words[shadow_fill] = word;
          shadow_fill++;
        end
      end
      OP_POP: begin
        if (shadow_fill == 0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          shadow_fill--;
          res.data = shadow_words[shadow_fill];
        end
      end
      OP_PEEK: begin
        // distance from the top, 1 is the top entry
        if (pos == 0 || pos > shadow_fill) res.status = ST_RANGE;
        else res.data = shadow_words[shadow_fill - pos];
      end
      default: begin
        // change: index counted from the bottom
        if (pos >= shadow_fill) res.status = ST_RANGE;
        else shadow_words[pos] = word;
      end
    endcase
    res.depth = DEPTH_W'(shadow_fill);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  // The strobe is sampled before the edge updates land, so the values seen
  // here are the ones accepted at this edge.
  always @(posedge clk_i) begin : check_results
    stack_result_t want;
    if (rst_ni && valid_o) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got data %h status %0d depth %0d",
                 $time, data_o, status_o, depth_o);
        error_count++;
      end else begin
        want = results_due.pop_front();
        if (data_o !== want.data) begin
          $display("%0t: data mismatch, expected %h, got %h", $time, want.data, data_o);
          error_count++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, status_o);
          error_count++;
        end
        if (depth_o !== want.depth) begin
          $display("%0t: depth mismatch, expected %0d, got %0d",
                   $time, want.depth, depth_o);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Sends one command. Start is left high after acceptance so a back-to-back
  // command does not drop and raise it in the same step; a gap or a drain
  // lowers it.
  task automatic send_op(ils_op_e op, logic signed [VAL_W-1:0] word,
                         logic [POS_W-1:0] pos);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    op_i       <= op;
    value_i    <= word;
    position_i <= pos;
    do @(posedge clk_i); while (busy);
    results_due.push_back(apply_stack_op(op, word, pos));
  endtask

  // Stops issuing and waits until every predicted beat has arrived.
  task automatic drain_stack_results();
    start <= 1'b0;
    while (results_due.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Capacity writes happen only with the block idle.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_stack_results();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i        <= 1'b0;
    shadow_capacity = cap;
  endtask

  // Mostly random words, with the extremes mixed in.
  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Pop, peek and change on an empty stack are all errors of some kind.
  task automatic test_empty_stack();
    send_op(OP_POP,    '0, '0);           // underflow
    send_op(OP_PEEK,   '0, POS_W'(1));    // nothing to peek
    send_op(OP_PEEK,   '0, '0);           // position zero
    send_op(OP_CHANGE, WORD_MAX, '0);     // no entry at the bottom yet
  endtask

  // Word extremes through push, peek, change and pop; leaves depth 3.
  task automatic test_word_extremes();
    send_op(OP_PUSH,   WORD_MIN, '0);
    send_op(OP_PUSH,   WORD_MAX, '1);
    send_op(OP_PUSH,   '0, '0);
    send_op(OP_PUSH,   '1, '1);
    send_op(OP_PEEK,   '0, POS_W'(1));    // top
    send_op(OP_PEEK,   '0, POS_W'(4));    // bottom
    send_op(OP_PEEK,   '0, POS_W'(5));    // one past the bottom
    send_op(OP_PEEK,   '0, '1);           // largest position
    send_op(OP_CHANGE, 32'sh5A5A_A5A5, '0);
    send_op(OP_CHANGE, 32'sh0F0F_F0F0, POS_W'(3));
    send_op(OP_CHANGE, WORD_MIN, POS_W'(4));  // index equal to depth
    send_op(OP_CHANGE, WORD_MIN, '1);
    send_op(OP_PEEK,   '0, POS_W'(4));    // changed bottom entry
    send_op(OP_POP,    '0, '0);
  endtask

  // Capacity dropped under the current depth: entries stay, pushes overflow.
  task automatic test_capacity_lowered();
    write_capacity('0);                   // acts as one
    send_op(OP_PUSH,   pick_word(), '0);
    send_op(OP_PEEK,   '0, POS_W'(3));
    send_op(OP_CHANGE, pick_word(), POS_W'(2));
    send_op(OP_POP,    '0, '0);
    send_op(OP_POP,    '0, '0);
    send_op(OP_POP,    '0, '0);
    send_op(OP_PUSH,   pick_word(), '0);  // fits: depth 0 below one
    send_op(OP_PUSH,   pick_word(), '0);  // full at one
    write_capacity(CAP_W'(2));
    send_op(OP_PUSH,   pick_word(), '0);
    send_op(OP_PUSH,   pick_word(), '0);
    send_op(OP_POP,    '0, '0);
    send_op(OP_POP,    '0, '0);
  endtask

  // Fill the whole row, touch its far end, then empty it with a tiny capacity.
  task automatic test_full_stack();
    write_capacity(CAP_W'(300));          // saturates to the row length
    burst_mode = ($urandom_range(0, 1) == 0);
    while (shadow_fill < MAX_DEPTH) send_op(OP_PUSH, pick_word(), '0);
    send_op(OP_PUSH,   pick_word(), '0);  // overflow at the row length
    send_op(OP_PEEK,   '0, POS_W'(MAX_DEPTH));
    send_op(OP_PEEK,   '0, POS_W'(MAX_DEPTH + 1));
    send_op(OP_CHANGE, pick_word(), POS_W'(MAX_DEPTH - 1));
    send_op(OP_CHANGE, pick_word(), POS_W'(MAX_DEPTH));
    send_op(OP_PEEK,   '0, POS_W'(1));
    write_capacity(CAP_W'(5));
    burst_mode = 1'b0;
    send_op(OP_PUSH,   pick_word(), '0);
    while (shadow_fill > 0) send_op(OP_POP, '0, POS_W'(pick_word()));
    send_op(OP_POP,    '0, '0);
  endtask

  // Random commands under one capacity setting. The push share drops once the
  // stack gets deep, so depth wanders but pops stay reasonably quick.
  task automatic test_random_ops(logic [CAP_W-1:0] cap);
    ils_op_e          op;
    int unsigned      roll;
    int unsigned      push_share;
    logic [POS_W-1:0] pos;
    write_capacity(cap);
    for (int i = 0; i < OPS_PER_PHASE; i++) begin
      // stretches of back-to-back commands between gappy ones
      if (i % 50 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      push_share = (shadow_fill > 40) ? 30 : 45;
      roll = $urandom_range(0, 99);
      if (roll < push_share) op = OP_PUSH;
      else if (roll < push_share + 30) op = OP_POP;
      else if (roll < 88) op = OP_PEEK;
      else op = OP_CHANGE;
      case ($urandom_range(0, 9))
        0: pos = '0;
        1: pos = POS_W'(shadow_fill);
        2: pos = POS_W'(shadow_fill + 1);
        3: pos = POS_W'($urandom_range(0, (1 << POS_W) - 1));
        default: begin
          // mostly a position that hits a held entry
          if (shadow_fill == 0) pos = POS_W'($urandom_range(0, 3));
          else if (op == OP_CHANGE) pos = POS_W'($urandom_range(0, shadow_fill - 1));
          else pos = POS_W'($urandom_range(1, shadow_fill));
        end
      endcase
      send_op(op, pick_word(), pos);
    end
    burst_mode = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_stack();
    test_word_extremes();
    test_capacity_lowered();
    test_full_stack();
    test_random_ops('1);                              // all ones, saturates
    test_random_ops('0);                              // acts as one
    test_random_ops(CAP_W'($urandom_range(2, 12)));
    test_random_ops(CAP_W'(MAX_DEPTH));
    test_random_ops(CAP_W'($urandom_range(13, 255)));

    drain_stack_results();
    // room for any stray beat; a pop from a full row is the slowest
    repeat (MAX_DEPTH + 4) @(posedge clk_i);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
